>>> hw/rtl/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types and character codes for the dotted IPv4 text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dip_pkg;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned MAX_SAVED = 3;

    // result of one parse step
    typedef struct packed {
        logic              emit;
        logic              ok;
        logic [ADDR_W-1:0] address;
    } dip_res_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dotted_ipv4_text_parser_top.sv
// ----------------------------------------------------------------------------
// dotted_ipv4_text_parser_top
// Character-stream parser for dotted IPv4 address text.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while it is not stalled, and keeps
// taking characters back to back. Each word is held in the input register and
// is parsed against the parser state. If the character ends the parse, its
// result is loaded into the output register at the next edge. So the character
// that ends the parse passes the input register and then the output register
// before its result is valid. The accumulator update, a shift or shift-add of
// the running part value, is combinational within the parse step. The input
// side stalls only while a word in the input register cannot move on because
// the output register is full and not being taken.
`default_nettype none

module dotted_ipv4_text_parser_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output wire logic                        in_ready,
    input  wire logic [7:0]                  ch,
    input  wire logic                        start_req,
    output wire logic                        out_valid,
    input  wire logic                        out_ready,
    output wire logic                        ok,
    output wire logic [dip_pkg::ADDR_W-1:0]  address
);

    logic                        in_valid_reg;
    logic [7:0]                  ch_reg;
    logic                        start_reg;
    logic                        out_valid_reg;
    logic                        ok_reg;
    logic [dip_pkg::ADDR_W-1:0]  address_reg;
    logic                        out_free;
    logic                        step_fire;
    dip_pkg::dip_res_t           res;

    // handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign step_fire = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || step_fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg    <= ch;
            start_reg <= start_req;
        end
    end

    // parse step
    dip_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (step_fire),
        .ch        (ch_reg),
        .start_req (start_reg),
        .res       (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step_fire && res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && res.emit)
        begin
            ok_reg      <= res.ok;
            address_reg <= res.address;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign address   = address_reg;

    // checks
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> address == '0)
        else $error("failed result with nonzero address");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && res.emit |=> out_valid)
        else $error("emitted result not in output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |-> !out_valid_reg || out_ready)
        else $error("parse step while output register is held");

endmodule

`default_nettype wire

>>> hw/rtl/dip_parse.sv
// ----------------------------------------------------------------------------
// dip_parse
// Parser state and the per-character update: phase, radix, accumulator,
// saved parts and the final layout with range checks.
// ----------------------------------------------------------------------------
`default_nettype none

module dip_parse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [7:0]        ch,
    input  wire logic              start_req,
    output dip_pkg::dip_res_t      res
);

    typedef enum logic [1:0] {
        PH_DONE,
        PH_START,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_OCT,
        RX_HEX
    } radix_t;

    localparam int unsigned W = dip_pkg::ADDR_W;

    phase_t         phase_reg, phase_next;
    radix_t         radix_reg, radix_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic [1:0]     part_cnt_reg, part_cnt_next;
    logic [W-1:0]   saved_reg [dip_pkg::MAX_SAVED];

    phase_t         phase_eff;
    logic [1:0]     part_cnt_eff;
    radix_t         radix_in;
    logic [W-1:0]   acc_in;
    logic [W-1:0]   acc_mul;
    logic           save;

    // a start flag restarts the parse with this character
    assign phase_eff    = start_req ? PH_START : phase_reg;
    assign part_cnt_eff = start_req ? 2'd0 : part_cnt_reg;

    // operands of the digit step
    always_comb
    begin
        case (phase_eff)
            PH_START: radix_in = RX_DEC;
            PH_ZERO:  radix_in = RX_OCT;
            default:  radix_in = radix_reg;
        endcase
        acc_in = (phase_eff == PH_DIGITS) ? acc_reg : '0;
    end

    // accumulator times base by shifts, with an add for decimal
    always_comb
    begin
        case (radix_in)
            RX_HEX:  acc_mul = {acc_in[W-5:0], 4'b0000};
            RX_OCT:  acc_mul = {acc_in[W-4:0], 3'b000};
            default: acc_mul = {acc_in[W-4:0], 3'b000} + {acc_in[W-2:0], 1'b0};
        endcase
    end

    // next state and result
    always_comb
    begin
        logic do_digits;
        logic hex_lo;
        logic hex_hi;
        logic [3:0] nib;

        phase_next    = phase_eff;
        radix_next    = radix_reg;
        acc_next      = acc_reg;
        part_cnt_next = part_cnt_eff;
        save          = 1'b0;
        res           = '0;
        do_digits     = 1'b0;
        hex_lo        = (ch >= dip_pkg::CH_LO_A) && (ch <= dip_pkg::CH_LO_F);
        hex_hi        = (ch >= dip_pkg::CH_UP_A) && (ch <= dip_pkg::CH_UP_F);
        nib           = ch[3:0] + 4'd9;

        case (phase_eff)
            PH_START:
            begin
                if (!dip_pkg::is_dec(ch))
                begin
                    res.emit   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    acc_next = '0;
                    if (ch == dip_pkg::CH_0)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        radix_next = RX_DEC;
                        phase_next = PH_DIGITS;
                        do_digits  = 1'b1;
                    end
                end
            end
            PH_ZERO:
            begin
                phase_next = PH_DIGITS;
                if (ch == dip_pkg::CH_LO_X || ch == dip_pkg::CH_UP_X)
                begin
                    radix_next = RX_HEX;
                end
                else
                begin
                    radix_next = RX_OCT;
                    do_digits  = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                do_digits = 1'b1;
            end
            default:
            begin
                do_digits = 1'b0;
            end
        endcase

        // one character of a part, a dot or a terminator
        if (do_digits)
        begin
            if (dip_pkg::is_dec(ch))
            begin
                acc_next = acc_mul + {{(W-4){1'b0}}, ch[3:0]};
            end
            else if (radix_in == RX_HEX && (hex_lo || hex_hi))
            begin
                acc_next = {acc_in[W-5:0], nib};
            end
            else if (ch == dip_pkg::CH_DOT)
            begin
                if (part_cnt_eff == 2'd3)
                begin
                    res.emit   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    save          = 1'b1;
                    part_cnt_next = part_cnt_eff + 2'd1;
                    phase_next    = PH_START;
                end
            end
            else if (ch == dip_pkg::CH_NUL || dip_pkg::is_ws(ch))
            begin
                res.emit   = 1'b1;
                phase_next = PH_DONE;
                case (part_cnt_eff)
                    2'd0:
                    begin
                        res.ok      = 1'b1;
                        res.address = acc_in;
                    end
                    2'd1:
                    begin
                        res.ok = (acc_in[31:24] == 8'd0) && (saved_reg[0][31:8] == '0);
                        res.address = {saved_reg[0][7:0], acc_in[23:0]};
                    end
                    2'd2:
                    begin
                        res.ok = (acc_in[31:16] == 16'd0) &&
                                 (saved_reg[0][31:8] == '0) &&
                                 (saved_reg[1][31:8] == '0);
                        res.address = {saved_reg[0][7:0], saved_reg[1][7:0],
                                       acc_in[15:0]};
                    end
                    default:
                    begin
                        res.ok = (acc_in[31:8] == 24'd0) &&
                                 (saved_reg[0][31:8] == '0) &&
                                 (saved_reg[1][31:8] == '0) &&
                                 (saved_reg[2][31:8] == '0);
                        res.address = {saved_reg[0][7:0], saved_reg[1][7:0],
                                       saved_reg[2][7:0], acc_in[7:0]};
                    end
                endcase
                if (!res.ok)
                begin
                    res.address = '0;
                end
            end
            else
            begin
                res.emit   = 1'b1;
                phase_next = PH_DONE;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DONE;
            radix_reg    <= RX_DEC;
            acc_reg      <= '0;
            part_cnt_reg <= 2'd0;
        end
        else if (en)
        begin
            phase_reg    <= phase_next;
            radix_reg    <= radix_next;
            acc_reg      <= acc_next;
            part_cnt_reg <= part_cnt_next;
        end
    end

    // saved parts, no reset
    always_ff @(posedge clk)
    begin
        if (en && save)
        begin
            saved_reg[part_cnt_eff] <= acc_in;
        end
    end

endmodule

`default_nettype wire
